[hdl/bsfr_pkg.sv]
// ----------------------------------------------------------------------------
// bsfr_pkg - shared types and constants of the byte-stuffed frame receiver
// Transaction structs, command and result codes, register indexes, frame
// store sizing and the reflected CRC-16 byte update.
// ----------------------------------------------------------------------------
`default_nettype none

package bsfr_pkg;

   // Frame store sizing
   localparam int FRAME_DEPTH = 256;
   localparam int ADDR_W      = $clog2(FRAME_DEPTH);
   localparam int CNT_W       = $clog2(FRAME_DEPTH + 1);

   // Output queue sizing
   localparam int OUTQ_DEPTH = 3;
   localparam int OUTQ_PTR_W = 2;
   localparam int OUTQ_CNT_W = 2;

   // CRC-16 constants (reflected 0x1021)
   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'h8408;
   localparam logic [15:0] CRC_XOUT = 16'hFFFF;

   // Register reset values
   localparam logic [7:0] FLAG_RESET   = 8'h7E;
   localparam logic [7:0] ESCAPE_RESET = 8'h7D;
   localparam logic [7:0] MASK_RESET   = 8'h20;

   typedef enum logic {
      CMD_FEED = 1'b0,
      CMD_READ = 1'b1
   } command_type;

   typedef enum logic [1:0] {
      EV_NONE = 2'd0,
      EV_GOOD = 2'd1,
      EV_BAD  = 2'd2
   } event_type;

   typedef enum logic [1:0] {
      CSR_FLAG   = 2'd0,
      CSR_ESCAPE = 2'd1,
      CSR_MASK   = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic       command;
      logic [7:0] rx_byte;
      logic [7:0] read_index;
   } req_type;

   typedef struct packed {
      event_type  event_res;
      logic [7:0] payload_length;
      logic [7:0] read_data;
   } rsp_type;

   // One byte through the reflected CRC, bit at a time
   function automatic logic [15:0] crc_add_byte(input logic [15:0] crc,
                                                input logic [7:0]  b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int k = 0; k < 8; k++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

`default_nettype wire

[hdl/bsfr_ram.sv]
// ----------------------------------------------------------------------------
// bsfr_ram - generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module bsfr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[hdl/bsfr_outq.sv]
// ----------------------------------------------------------------------------
// bsfr_outq - result queue
// Three-entry queue in flops between the result stage and the response
// channel; the producer checks space through the fill count.
// ----------------------------------------------------------------------------
`default_nettype none

module bsfr_outq (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         push,
   input  wire bsfr_pkg::rsp_type            push_data,
   output logic                              pop_valid,
   input  wire logic                         pop_ready,
   output bsfr_pkg::rsp_type                 pop_data,
   output logic [bsfr_pkg::OUTQ_CNT_W-1:0]   count
);

   localparam logic [bsfr_pkg::OUTQ_PTR_W-1:0] LAST_PTR =
      bsfr_pkg::OUTQ_PTR_W'(bsfr_pkg::OUTQ_DEPTH - 1);

   bsfr_pkg::rsp_type                     entry_ff [bsfr_pkg::OUTQ_DEPTH];
   logic [bsfr_pkg::OUTQ_PTR_W-1:0]       head_ff, head_in;
   logic [bsfr_pkg::OUTQ_PTR_W-1:0]       tail_ff, tail_in;
   logic [bsfr_pkg::OUTQ_CNT_W-1:0]       count_ff, count_in;
   logic                                  pop;

   assign pop = pop_valid && pop_ready;

   // Pointer and fill count update
   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      if (pop) begin
         head_in = (head_ff == LAST_PTR) ? '0 : head_ff + 1'b1;
      end
      if (push) begin
         tail_in = (tail_ff == LAST_PTR) ? '0 : tail_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   // Entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[tail_ff] <= push_data;
      end
   end

   assign pop_valid = (count_ff != '0);
   assign pop_data  = entry_ff[head_ff];
   assign count     = count_ff;

endmodule

`default_nettype wire

[hdl/byte_stuffed_frame_receiver_crc16_top.sv]
// ----------------------------------------------------------------------------
// byte_stuffed_frame_receiver_crc16_top - flag/escape deframer with CRC-16
// Strips flag and escape framing from received bytes, stores the frame in a
// RAM and checks the trailing CRC-16 at the closing flag.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  : one transaction per byte. command FEED pushes rx_byte through the
//            deframer; command READ fetches frame store entry read_index.
//   rsp_*  : exactly one result per request, in request order: event_res,
//            payload_length (good frames) and read_data (reads).
//   csr_*  : register writes (flag, escape, escape mask); always ready. Write
//            only while no request is in flight.
// Path: a request's result is registered in the result stage together with
//   the deframer update and the frame store read data, then pushed into the
//   result queue, which offers it on the response channel.
// Throughput: one request per cycle while req_ready is high. The frame store
//   has separate read and write ports and the CRC update is a combinational byte step.
// Stall: a three-entry result queue holds pending results; req_ready drops
//   only when the queue plus the result stage hold three results.
// Reset: clears the deframer state and registers to their defaults at once.
//   The frame store is not cleared; entries read before being written are
//   undefined.
// ----------------------------------------------------------------------------
`default_nettype none

module byte_stuffed_frame_receiver_crc16_top (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire bsfr_pkg::req_type   req_data,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output bsfr_pkg::rsp_type        rsp_data,
   input  wire logic                csr_valid,
   output logic                     csr_ready,
   input  wire logic [1:0]          csr_index,
   input  wire logic [7:0]          csr_data
);

   localparam int CNT_W  = bsfr_pkg::CNT_W;
   localparam int ADDR_W = bsfr_pkg::ADDR_W;

   // Configuration registers
   logic [7:0] flag_ff, escape_ff, mask_ff;

   // Deframer state
   logic [CNT_W-1:0] count_ff, count_in;
   logic             inside_ff, inside_in;
   logic             esc_ff, esc_in;
   logic [15:0]      crc_ff, crc_in;
   logic [7:0]       older_ff, older_in;
   logic [7:0]       newer_ff, newer_in;

   // Result stage
   logic                    s1_valid_ff;
   logic                    s1_read_ff, s1_read_in;
   logic                    s1_range_ff, s1_range_in;
   bsfr_pkg::event_type     s1_event_ff, s1_event_in;
   logic [7:0]              s1_plen_ff, s1_plen_in;

   // Frame store ports
   logic              ram_we, ram_re;
   logic [7:0]        ram_wdata, ram_rdata;
   logic [ADDR_W-1:0] ram_waddr, ram_raddr;

   // Queue signals
   logic [bsfr_pkg::OUTQ_CNT_W-1:0] outq_count;
   bsfr_pkg::rsp_type               outq_push_data;

   logic              accept, is_read;
   logic [7:0]        data_byte;
   logic [15:0]       crc_step;
   logic [15:0]       got_crc;
   logic [CNT_W-1:0]  len;

   assign csr_ready = 1'b1;

   // Register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         flag_ff   <= bsfr_pkg::FLAG_RESET;
         escape_ff <= bsfr_pkg::ESCAPE_RESET;
         mask_ff   <= bsfr_pkg::MASK_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            bsfr_pkg::CSR_FLAG:   flag_ff   <= csr_data;
            bsfr_pkg::CSR_ESCAPE: escape_ff <= csr_data;
            bsfr_pkg::CSR_MASK:   mask_ff   <= csr_data;
            default: ;
         endcase
      end
   end

   // Space check: results in flight never exceed the queue depth
   assign req_ready = ({1'b0, outq_count} + {2'b00, s1_valid_ff}) <= 3'd2;
   assign accept    = req_valid && req_ready;
   assign is_read   = (req_data.command == bsfr_pkg::CMD_READ);

   assign data_byte = esc_ff ? (req_data.rx_byte ^ mask_ff) : req_data.rx_byte;
   assign crc_step  = bsfr_pkg::crc_add_byte(crc_ff, older_ff);
   assign got_crc   = {newer_ff, older_ff};
   assign len       = count_ff - CNT_W'(2);

   // Deframer next state, store write and result stage contents
   always_comb begin
      count_in    = count_ff;
      inside_in   = inside_ff;
      esc_in      = esc_ff;
      crc_in      = crc_ff;
      older_in    = older_ff;
      newer_in    = newer_ff;
      s1_read_in  = is_read;
      s1_range_in = (32'(req_data.read_index) < bsfr_pkg::FRAME_DEPTH);
      s1_event_in = bsfr_pkg::EV_NONE;
      s1_plen_in  = '0;
      ram_we      = 1'b0;
      ram_wdata   = data_byte;
      ram_waddr   = count_ff[ADDR_W-1:0];

      if (!is_read) begin
         if (req_data.rx_byte == flag_ff) begin
            if (inside_ff && (count_ff != '0)) begin
               count_in = '0;
               crc_in   = bsfr_pkg::CRC_INIT;
               if (count_ff < CNT_W'(2)) begin
                  // short frame: escape stays pending
                  s1_event_in = bsfr_pkg::EV_BAD;
               end else begin
                  esc_in = 1'b0;
                  if (got_crc == (crc_ff ^ bsfr_pkg::CRC_XOUT)) begin
                     s1_event_in = bsfr_pkg::EV_GOOD;
                     s1_plen_in  = (32'(len) > 255) ? 8'hFF : 8'(len);
                  end else begin
                     s1_event_in = bsfr_pkg::EV_BAD;
                  end
               end
            end else begin
               // open or reopen
               inside_in = 1'b1;
               count_in  = '0;
               crc_in    = bsfr_pkg::CRC_INIT;
               esc_in    = 1'b0;
            end
         end else if (inside_ff) begin
            if (req_data.rx_byte == escape_ff) begin
               esc_in = 1'b1;
            end else begin
               esc_in = 1'b0;
               if (count_ff < CNT_W'(bsfr_pkg::FRAME_DEPTH)) begin
                  if (count_ff >= CNT_W'(2)) begin
                     crc_in = crc_step;
                  end
                  older_in = newer_ff;
                  newer_in = data_byte;
                  ram_we   = 1'b1;
                  count_in = count_ff + 1'b1;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         inside_ff <= 1'b0;
         esc_ff    <= 1'b0;
         crc_ff    <= bsfr_pkg::CRC_INIT;
         older_ff  <= '0;
         newer_ff  <= '0;
      end else if (accept) begin
         count_ff  <= count_in;
         inside_ff <= inside_in;
         esc_ff    <= esc_in;
         crc_ff    <= crc_in;
         older_ff  <= older_in;
         newer_ff  <= newer_in;
      end
   end

   // Result stage: always drains into the queue the next cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_read_ff  <= s1_read_in;
         s1_range_ff <= s1_range_in;
         s1_event_ff <= s1_event_in;
         s1_plen_ff  <= s1_plen_in;
      end
   end

   assign ram_re    = accept && is_read;
   assign ram_raddr = ADDR_W'(req_data.read_index);

   bsfr_ram #(
      .WIDTH(8),
      .DEPTH(bsfr_pkg::FRAME_DEPTH)
   ) u_frame_store (
      .clock  (clock),
      .wr_en  (ram_we && accept),
      .wr_addr(ram_waddr),
      .wr_data(ram_wdata),
      .rd_en  (ram_re),
      .rd_addr(ram_raddr),
      .rd_data(ram_rdata)
   );

   // Queue entry for the finished transaction
   always_comb begin
      outq_push_data.event_res      = s1_event_ff;
      outq_push_data.payload_length = s1_plen_ff;
      outq_push_data.read_data      = (s1_read_ff && s1_range_ff) ? ram_rdata : 8'h00;
   end

   bsfr_outq u_outq (
      .clock    (clock),
      .reset    (reset),
      .push     (s1_valid_ff),
      .push_data(outq_push_data),
      .pop_valid(rsp_valid),
      .pop_ready(rsp_ready),
      .pop_data (rsp_data),
      .count    (outq_count)
   );

   // Checks
   a_outq_no_overflow: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && (outq_count == 2'd3)) |-> (rsp_valid && rsp_ready))
      else $error("result queue overflow");

   a_store_in_range: assert property (@(posedge clock) disable iff (reset)
      (ram_we && accept) |-> (count_ff < CNT_W'(bsfr_pkg::FRAME_DEPTH)))
      else $error("frame store write beyond depth");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(bsfr_pkg::FRAME_DEPTH))
      else $error("stored count beyond depth");

   a_read_follows: assert property (@(posedge clock) disable iff (reset)
      (accept && is_read) |=> (s1_valid_ff && s1_read_ff && (s1_event_ff == bsfr_pkg::EV_NONE)))
      else $error("read transaction lost in result stage");

endmodule

`default_nettype wire

[sim/frame_result_checker.sv]
// ----------------------------------------------------------------------------
// frame_result_checker - deframer prediction and result comparison
// Watches the request, result and register channels of the byte-stuffed frame
// receiver, keeps its own copy of the deframer state and compares every
// result with the oldest predicted one.
// ----------------------------------------------------------------------------
`default_nettype none

package bsfr_tb_pkg;

   // Reflected CRC-16, one data bit folded into the low bit per shift
   function automatic logic [15:0] fcs16_update(input logic [15:0] fcs,
                                                input logic [7:0]  data);
      logic [15:0] f;
      f = fcs;
      for (int i = 0; i < 8; i++) begin
         f = (f >> 1) ^ ((f[0] ^ data[i]) ? 16'h8408 : 16'h0000);
      end
      return f;
   endfunction

endpackage

module frame_result_checker
   import bsfr_pkg::*;
   import bsfr_tb_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   input  wire logic            req_ready,
   input  wire req_type         req_data,
   input  wire logic            rsp_valid,
   input  wire logic            rsp_ready,
   input  wire rsp_type         rsp_data,
   input  wire logic            csr_valid,
   input  wire logic            csr_ready,
   input  wire logic [1:0]      csr_index,
   input  wire logic [7:0]      csr_data,
   output int                   mismatch_count,
   output int                   awaited_count,
   output int                   written_extent,
   output int                   good_frames,
   output int                   bad_frames,
   output int                   store_reads,
   output int                   results_seen
);

   // Predicted deframer state
   logic [7:0]  store_img [FRAME_DEPTH];
   int          fill;
   bit          frame_open;
   bit          esc_armed;
   logic [15:0] fcs;
   logic [7:0]  held_lo;
   logic [7:0]  held_hi;
   int          extent;

   // Register copies
   logic [7:0]  flag_v;
   logic [7:0]  esc_v;
   logic [7:0]  mask_v;

   // Results predicted but not yet seen, oldest first
   rsp_type     awaited_rsp [$];

   // One request through the deframer; returns the result it causes
   function automatic rsp_type deframe_step(input req_type r);
      rsp_type    o;
      logic [7:0] b;
      int         len;
      o.event_res      = EV_NONE;
      o.payload_length = '0;
      o.read_data      = '0;
      b = r.rx_byte;
      if (r.command == CMD_READ) begin
         if (int'(r.read_index) < FRAME_DEPTH) begin
            o.read_data = store_img[r.read_index];
         end
      end else if (b == flag_v) begin
         // flag beats escape and a pending escape
         if (frame_open && fill > 0) begin
            if (fill >= 2) begin
               len = fill - 2;
               if ({held_hi, held_lo} == ~fcs) begin
                  o.event_res      = EV_GOOD;
                  o.payload_length = (len > 255) ? 8'd255 : 8'(len);
               end else begin
                  o.event_res = EV_BAD;
               end
               esc_armed = 1'b0;
            end else begin
               // short frame: pending escape survives
               o.event_res = EV_BAD;
            end
            fill = 0;
            fcs  = 16'hFFFF;
         end else begin
            frame_open = 1'b1;
            fill       = 0;
            fcs        = 16'hFFFF;
            esc_armed  = 1'b0;
         end
      end else if (frame_open) begin
         if (b == esc_v) begin
            esc_armed = 1'b1;
         end else begin
            if (esc_armed) begin
               b = b ^ mask_v;
               esc_armed = 1'b0;
            end
            // store full: byte dropped, CRC and holdback untouched
            if (fill < FRAME_DEPTH) begin
               if (fill >= 2) begin
                  fcs = fcs16_update(fcs, held_lo);
               end
               held_lo = held_hi;
               held_hi = b;
               store_img[fill] = b;
               fill++;
               if (fill > extent) begin
                  extent = fill;
               end
            end
         end
      end
      return o;
   endfunction

   // Sample all three channels at each edge
   always @(posedge clock) begin : watch
      rsp_type want;
      rsp_type got;
      if (reset) begin
         fill       = 0;
         frame_open = 1'b0;
         esc_armed  = 1'b0;
         fcs        = 16'hFFFF;
         held_lo    = '0;
         held_hi    = '0;
         extent     = 0;
         flag_v     = FLAG_RESET;
         esc_v      = ESCAPE_RESET;
         mask_v     = MASK_RESET;
         awaited_rsp.delete();
         mismatch_count <= 0;
         awaited_count  <= 0;
         written_extent <= 0;
         good_frames    <= 0;
         bad_frames     <= 0;
         store_reads    <= 0;
         results_seen   <= 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index_type'(csr_index))
               CSR_FLAG:   flag_v = csr_data;
               CSR_ESCAPE: esc_v  = csr_data;
               CSR_MASK:   mask_v = csr_data;
               default: ;
            endcase
         end

         if (req_valid && req_ready) begin
            want = deframe_step(req_data);
            awaited_rsp.push_back(want);
            if (want.event_res == EV_GOOD) begin
               good_frames <= good_frames + 1;
            end
            if (want.event_res == EV_BAD) begin
               bad_frames <= bad_frames + 1;
            end
            if (req_data.command == CMD_READ) begin
               store_reads <= store_reads + 1;
            end
         end

         if (rsp_valid && rsp_ready) begin
            got = rsp_data;
            results_seen <= results_seen + 1;
            if (awaited_rsp.size() == 0) begin
               mismatch_count <= mismatch_count + 1;
               if (mismatch_count < 10) begin
                  $display("[%0t] unexpected result: event %0d len %0d data %02h",
                           $realtime, got.event_res, got.payload_length, got.read_data);
               end
            end else begin
               want = awaited_rsp.pop_front();
               if (got.event_res !== want.event_res ||
                   got.payload_length !== want.payload_length ||
                   got.read_data !== want.read_data) begin
                  mismatch_count <= mismatch_count + 1;
                  if (mismatch_count < 10) begin
                     $display("[%0t] result %0d: expected event %0d len %0d data %02h",
                              $realtime, results_seen, want.event_res,
                              want.payload_length, want.read_data);
                     $display("[%0t] result %0d:      got event %0d len %0d data %02h",
                              $realtime, results_seen, got.event_res,
                              got.payload_length, got.read_data);
                  end
               end
            end
         end

         awaited_count  <= awaited_rsp.size();
         written_extent <= extent;
      end
   end

endmodule

`default_nettype wire

[sim/byte_stuffed_frame_receiver_crc16_top_tb.sv]
// ----------------------------------------------------------------------------
// byte_stuffed_frame_receiver_crc16_top_tb - stimulus and verdict
// Drives framed and unframed byte streams and store reads into the deframer
// under several register settings and idle patterns, including a long
// result hold-off; the checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
`default_nettype none

module byte_stuffed_frame_receiver_crc16_top_tb;
   import bsfr_pkg::*;
   import bsfr_tb_pkg::*;

   localparam int PHASES      = 6;
   localparam int PHASE_ITEMS = 65;
   localparam int DRAIN_LIMIT = 2000;
   localparam int HOLD_CYCLES = 60;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   req_type     req_data;
   logic        rsp_valid;
   logic        rsp_ready;
   rsp_type     rsp_data;
   logic        csr_valid;
   logic        csr_ready;
   logic [1:0]  csr_index;
   logic [7:0]  csr_data;

   int          mismatch_count;
   int          awaited_count;
   int          written_extent;
   int          good_frames;
   int          bad_frames;
   int          store_reads;
   int          results_seen;

   // Stimulus-side view of the registers
   logic [7:0]  cfg_flag   = FLAG_RESET;
   logic [7:0]  cfg_escape = ESCAPE_RESET;
   logic [7:0]  cfg_mask   = MASK_RESET;

   int          req_gap_pct   = 0;
   int          rsp_stall_pct = 0;
   bit          hold_request  = 1'b0;
   int          items_sent    = 0;
   int          settings_used = 1;

   byte_stuffed_frame_receiver_crc16_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   frame_result_checker result_check (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_data       (rsp_data),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .mismatch_count (mismatch_count),
      .awaited_count  (awaited_count),
      .written_extent (written_extent),
      .good_frames    (good_frames),
      .bad_frames     (bad_frames),
      .store_reads    (store_reads),
      .results_seen   (results_seen)
   );

   // Clock
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Run limit
   initial begin
      #2000000;
      $display("Mismatches found");
      $finish;
   end

   // Result side: random stalls, or one long hold-off on request
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_request = 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
         end
      end
   end

   function automatic req_type feed_req(input logic [7:0] b);
      req_type r;
      r.command    = CMD_FEED;
      r.rx_byte    = b;
      r.read_index = 8'($urandom);
      return r;
   endfunction

   function automatic req_type read_req(input logic [7:0] idx);
      req_type r;
      r.command    = CMD_READ;
      r.rx_byte    = 8'($urandom);
      r.read_index = idx;
      return r;
   endfunction

   // Frame content leaning towards the framing codes
   function automatic logic [7:0] pick_byte();
      int r;
      r = $urandom_range(9);
      if (r == 0) begin
         return cfg_flag;
      end else if (r == 1) begin
         return cfg_escape;
      end
      return 8'($urandom);
   endfunction

   // One transaction, after a random gap on the request side
   task automatic send_item(input req_type item);
      while ($urandom_range(99) < req_gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
      items_sent++;
   endtask

   // Escape framing codes, and now and then an ordinary byte too
   task automatic send_stuffed(input logic [7:0] b);
      logic [7:0] x;
      x = b ^ cfg_mask;
      if (b == cfg_flag || b == cfg_escape ||
          ($urandom_range(9) == 0 && x != cfg_flag && x != cfg_escape)) begin
         send_item(feed_req(cfg_escape));
         send_item(feed_req(x));
      end else begin
         send_item(feed_req(b));
      end
   endtask

   // Optional opening flag, payload, trailing CRC, optional bytes past the CRC, closing flag
   task automatic send_frame(input int n_payload, input int n_extra,
                             input bit corrupt, input bit with_open);
      logic [7:0]  body [$];
      logic [15:0] fcs;
      logic [7:0]  b;
      fcs = 16'hFFFF;
      for (int i = 0; i < n_payload; i++) begin
         b = pick_byte();
         body.push_back(b);
         fcs = fcs16_update(fcs, b);
      end
      fcs = ~fcs;
      body.push_back(fcs[7:0]);
      body.push_back(fcs[15:8]);
      for (int i = 0; i < n_extra; i++) begin
         body.push_back(pick_byte());
      end
      if (corrupt) begin
         b = 8'($urandom_range(255, 1));
         body[$urandom_range(body.size() - 1)] ^= b;
      end
      if (with_open) begin
         send_item(feed_req(cfg_flag));
      end
      foreach (body[i]) begin
         send_stuffed(body[i]);
      end
      send_item(feed_req(cfg_flag));
   endtask

   // Wait until every predicted result has come back, or until the drain guard runs out
   task automatic wait_drained();
      int guard;
      req_valid <= 1'b0;
      guard = 0;
      @(posedge clock);
      while (awaited_count != 0 && guard < DRAIN_LIMIT) begin
         @(posedge clock);
         guard++;
      end
   endtask

   task automatic write_settings(input logic [7:0] flag_v, input logic [7:0] esc_v,
                                 input logic [7:0] mask_v);
      logic [7:0]    vals [3];
      csr_index_type idx  [3];
      vals = '{flag_v, esc_v, mask_v};
      idx  = '{CSR_FLAG, CSR_ESCAPE, CSR_MASK};
      wait_drained();
      for (int i = 0; i < 3; i++) begin
         csr_valid <= 1'b1;
         csr_index <= idx[i];
         csr_data  <= vals[i];
         do @(posedge clock); while (!csr_ready);
      end
      csr_valid <= 1'b0;
      cfg_flag   = flag_v;
      cfg_escape = esc_v;
      cfg_mask   = mask_v;
      settings_used++;
   endtask

   // Framing corner cases under the reset register values
   task automatic run_directed();
      send_item(feed_req(8'h00));                    // ignored outside a frame
      send_item(feed_req(8'hFF));
      send_item(feed_req(cfg_flag));                 // open
      send_item(feed_req(cfg_flag));                 // reopen, empty frame
      send_item(feed_req(cfg_escape));
      send_item(feed_req(cfg_escape));               // escape repeated
      send_item(feed_req(cfg_flag ^ cfg_mask));      // stores a flag value
      send_item(feed_req(cfg_escape));
      send_item(feed_req(cfg_flag));                 // short frame, escape kept
      send_item(feed_req(cfg_flag));                 // empty: clears escape
      send_item(feed_req(8'h00));                    // zero payload, CRC 0000
      send_item(feed_req(8'h00));
      send_item(feed_req(cfg_flag));
      send_item(read_req(8'd0));
      send_item(read_req(8'd1));
      send_item(feed_req(cfg_escape));
      send_item(feed_req(cfg_flag));                 // flag beats pending escape
      send_item(feed_req(8'h01));
      send_item(feed_req(8'h02));
      send_item(feed_req(8'h03));
      send_item(feed_req(cfg_flag));                 // CRC mismatch
      send_item(read_req(8'd2));
   endtask

   // Mostly well-formed frames, plus reads, noise and broken framing
   task automatic random_scenario();
      int r;
      int n;
      r = $urandom_range(99);
      if (r < 60) begin
         n = ($urandom_range(9) == 0) ? $urandom_range(40, 13) : $urandom_range(12);
         send_frame(n, 0, $urandom_range(99) < 15, $urandom_range(9) < 7);
      end else if (r < 75) begin
         n = $urandom_range(4, 1);
         for (int i = 0; i < n; i++) begin
            if (written_extent > 0) begin
               send_item(read_req(8'($urandom_range(written_extent - 1))));
            end else begin
               send_item(feed_req(pick_byte()));
            end
         end
      end else if (r < 90) begin
         n = $urandom_range(6, 1);
         for (int i = 0; i < n; i++) begin
            send_item(feed_req(($urandom_range(3) == 0) ? cfg_flag : pick_byte()));
         end
      end else begin
         case ($urandom_range(2))
            0: begin
               send_item(feed_req(cfg_flag));
               send_item(feed_req(8'($urandom)));
               send_item(feed_req(cfg_flag));
            end
            1: begin
               send_item(feed_req(cfg_flag));
               send_item(feed_req(8'($urandom)));
               send_item(feed_req(cfg_escape));
               send_item(feed_req(cfg_flag));
               send_item(feed_req(8'($urandom)));
            end
            default: begin
               send_item(feed_req(cfg_escape));
               send_item(feed_req(cfg_escape));
               send_item(feed_req(8'($urandom)));
               send_item(feed_req(cfg_flag));
            end
         endcase
      end
   endtask

   // Main sequence
   initial begin : stimulus
      int         start;
      logic [7:0] v;
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data  = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int p = 0; p < PHASES; p++) begin
         case (p)
            1: write_settings(8'h00, 8'hFF, 8'hFF);
            2: write_settings(8'hFF, 8'h00, 8'h00);
            3: write_settings(8'($urandom), 8'($urandom), 8'($urandom));
            4: begin
               v = 8'($urandom);
               write_settings(v, v, 8'($urandom));       // flag equals escape
            end
            5: write_settings(FLAG_RESET, ESCAPE_RESET, MASK_RESET);
            default: ;
         endcase

         case (p % 3)
            0: begin
               req_gap_pct   = 16;
               rsp_stall_pct = 47;
            end
            1: begin
               req_gap_pct   = 47;
               rsp_stall_pct = 16;
            end
            default: begin
               req_gap_pct   = 0;
               rsp_stall_pct = 0;
            end
         endcase

         if (p == 0) begin
            run_directed();
            // fill the store: largest payload, then bytes dropped when full
            send_frame(FRAME_DEPTH - 2, $urandom_range(3), 1'b0, 1'b1);
         end
         if (p == 3) begin
            hold_request = 1'b1;
         end

         start = items_sent;
         while (items_sent - start < PHASE_ITEMS) begin
            random_scenario();
         end
      end

      wait_drained();
      repeat (8) @(posedge clock);

      $display("Sent %0d transactions under %0d register settings; %0d results checked.",
               items_sent, settings_used, results_seen);
      $display("Frames good %0d, bad %0d; frame store reads %0d.",
               good_frames, bad_frames, store_reads);
      if (mismatch_count == 0 && awaited_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

`default_nettype wire

[filelist.f]
hdl/bsfr_pkg.sv
hdl/bsfr_ram.sv
hdl/bsfr_outq.sv
hdl/byte_stuffed_frame_receiver_crc16_top.sv
sim/frame_result_checker.sv
sim/byte_stuffed_frame_receiver_crc16_top_tb.sv
